[hw/rtl/mac_pkg.sv]
// Shared constants, types and helpers for the moving-average crossover block.
// No dependencies; the window, evaluation, top-level and testbench files import this package.
package mac_pkg;

  // Delay line depth, a power of two
  localparam int MAX_WINDOW = 256;
  localparam int PRICE_BITS = 32;

  localparam int HIST_AW    = $clog2(MAX_WINDOW);
  localparam int LEN_W      = HIST_AW + 1;
  localparam int PRICE_W    = 32;
  localparam int SUM_W      = PRICE_BITS + HIST_AW;
  localparam int PROD_W     = SUM_W + LEN_W;
  localparam int PNL_W      = 48;
  localparam int DELTA_W    = PRICE_BITS + 1;
  localparam int PNL_SUM_W  = ((PNL_W > DELTA_W) ? PNL_W : DELTA_W) + 1;
  localparam int CNT_W      = 16;
  localparam int STEP_W     = 8;
  localparam int CFG_LEN_W  = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LONG_LEN  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_EVAL_STEP = CFG_IDX_W'(2);

  localparam logic [CFG_LEN_W-1:0] SHORT_LEN_RST = CFG_LEN_W'(50);
  localparam logic [CFG_LEN_W-1:0] LONG_LEN_RST  = CFG_LEN_W'(150);
  localparam logic [STEP_W-1:0]    EVAL_STEP_RST = STEP_W'(5);

  // Signal codes, two's complement
  localparam logic [1:0] SIG_ZERO = 2'b00;
  localparam logic [1:0] SIG_POS  = 2'b01;
  localparam logic [1:0] SIG_NEG  = 2'b11;

  // Per-stage load strobes
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
    logic ld_out;
  } pipe_ctl_t;

  // Window stage result handed to the evaluation stages
  typedef struct packed {
    logic [SUM_W-1:0]      short_sum;
    logic [SUM_W-1:0]      long_sum;
    logic [PRICE_BITS-1:0] price;
    logic                  eval;
    logic                  ns;
  } win_out_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [CFG_LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (int'(v) > MAX_WINDOW) begin
      r = LEN_W'(MAX_WINDOW);
    end else begin
      r = LEN_W'(v);
    end
    return r;
  endfunction

  function automatic logic [STEP_W-1:0] clamp_step(input logic [STEP_W-1:0] v);
    return (v == '0) ? STEP_W'(1) : v;
  endfunction

endpackage

[hw/rtl/mac_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// Read of the address being written returns the old contents. No dependencies.
module mac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/mac_window.sv]
// Price delay line and running window sums, sample count and step phase.
// Depends on mac_pkg and mac_ram (two copies of the history, one per window tail).
module mac_window import mac_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  pipe_ctl_t             ctl,
  input  logic [PRICE_BITS-1:0] price_in,
  input  logic                  ns_in,
  input  logic [LEN_W-1:0]      s_len,
  input  logic [LEN_W-1:0]      l_len,
  input  logic [STEP_W-1:0]     step,
  input  logic                  resum,
  output logic                  busy,
  output win_out_t              win
);

  logic [HIST_AW-1:0]    wr_pos;
  logic [MAX_WINDOW-1:0] hvalid;
  logic [HIST_AW-1:0]    base, addr_s, addr_l, swp_addr, raddr_a;
  logic [PRICE_BITS-1:0] dout_a, dout_b;
  logic                  re_a;

  logic [PRICE_BITS-1:0] p1;
  logic                  ns1, mask_s1, mask_l1;

  logic [SUM_W-1:0]  short_sum, long_sum;
  logic [CNT_W-1:0]  count;
  logic [STEP_W-1:0] phase;

  logic [SUM_W-1:0]  old_s, old_l, ss_base, ls_base, ss_new, ls_new;
  logic [CNT_W-1:0]  cnt_base, cnt_new;
  logic [STEP_W-1:0] phase_base, phase_new;
  logic [STEP_W:0]   phase_inc;
  logic              full, eval_new;

  logic              swp_busy, swp_pend, swp_mask, swp_issue;
  logic [HIST_AW:0]  swp_cnt;
  logic [HIST_AW-1:0] swp_k;
  logic [SUM_W-1:0]  swp_add_s, swp_add_l;

  assign busy = swp_busy;

  // new_series restarts the line at entry 0
  always_comb begin
    base      = ns_in ? '0 : wr_pos;
    addr_s    = base - s_len[HIST_AW-1:0];
    addr_l    = base - l_len[HIST_AW-1:0];
    swp_issue = swp_busy & ~swp_cnt[HIST_AW];
    swp_addr  = wr_pos - HIST_AW'(1) - swp_cnt[HIST_AW-1:0];
    re_a      = ctl.ld1 | swp_issue;
    raddr_a   = swp_issue ? swp_addr : addr_s;
  end

  mac_ram #(.WIDTH(PRICE_BITS), .DEPTH(MAX_WINDOW)) u_hist_s (
    .clk   (clk),
    .we    (ctl.ld1),
    .waddr (base),
    .wdata (price_in),
    .re    (re_a),
    .raddr (raddr_a),
    .rdata (dout_a)
  );

  mac_ram #(.WIDTH(PRICE_BITS), .DEPTH(MAX_WINDOW)) u_hist_l (
    .clk   (clk),
    .we    (ctl.ld1),
    .waddr (base),
    .wdata (price_in),
    .re    (ctl.ld1),
    .raddr (addr_l),
    .rdata (dout_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos <= '0;
      hvalid <= '0;
    end else if (ctl.ld1) begin
      wr_pos <= base + HIST_AW'(1);
      hvalid <= ns_in ? MAX_WINDOW'(1) : (hvalid | (MAX_WINDOW'(1) << base));
    end
  end

  // Stage 1 payload; the outgoing tail sample is in the RAM read registers
  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      p1      <= price_in;
      ns1     <= ns_in;
      mask_s1 <= hvalid[addr_s] & ~ns_in;
      mask_l1 <= hvalid[addr_l] & ~ns_in;
    end
  end

  always_comb begin
    old_s      = mask_s1 ? SUM_W'(dout_a) : '0;
    old_l      = mask_l1 ? SUM_W'(dout_b) : '0;
    ss_base    = ns1 ? '0 : short_sum;
    ls_base    = ns1 ? '0 : long_sum;
    ss_new     = ss_base + SUM_W'(p1) - old_s;
    ls_new     = ls_base + SUM_W'(p1) - old_l;
    cnt_base   = ns1 ? '0 : count;
    cnt_new    = (cnt_base == CNT_MAX) ? cnt_base : cnt_base + CNT_W'(1);
    full       = cnt_new >= CNT_W'(l_len);
    phase_base = ns1 ? '0 : phase;
    phase_inc  = {1'b0, phase_base} + (STEP_W + 1)'(1);
    eval_new   = full & (phase_base == '0);
    if (!full) begin
      phase_new = phase_base;
    end else if (phase_inc >= {1'b0, step}) begin
      phase_new = '0;
    end else begin
      phase_new = phase_inc[STEP_W-1:0];
    end
    swp_add_s  = (swp_pend & swp_mask & ({1'b0, swp_k} < s_len)) ? SUM_W'(dout_a) : '0;
    swp_add_l  = (swp_pend & swp_mask & ({1'b0, swp_k} < l_len)) ? SUM_W'(dout_a) : '0;
  end

  // Sums follow a window-length write through a pass over the whole line
  always_ff @(posedge clk) begin
    if (rst) begin
      short_sum <= '0;
      long_sum  <= '0;
      count     <= '0;
      phase     <= '0;
    end else if (resum) begin
      short_sum <= '0;
      long_sum  <= '0;
    end else if (swp_busy) begin
      short_sum <= short_sum + swp_add_s;
      long_sum  <= long_sum + swp_add_l;
    end else if (ctl.ld2) begin
      short_sum <= ss_new;
      long_sum  <= ls_new;
      count     <= cnt_new;
      phase     <= phase_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      swp_busy <= 1'b0;
      swp_pend <= 1'b0;
      swp_cnt  <= '0;
    end else if (resum) begin
      swp_busy <= 1'b1;
      swp_pend <= 1'b0;
      swp_cnt  <= '0;
    end else if (swp_busy) begin
      swp_pend <= swp_issue;
      if (swp_issue) begin
        swp_cnt <= swp_cnt + (HIST_AW + 1)'(1);
      end else if (!swp_pend) begin
        swp_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (swp_issue) begin
      swp_k    <= swp_cnt[HIST_AW-1:0];
      swp_mask <= hvalid[swp_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      win.short_sum <= ss_new;
      win.long_sum  <= ls_new;
      win.price     <= p1;
      win.eval      <= eval_new;
      win.ns        <= ns1;
    end
  end

  a_no_item_in_pass: assert property (@(posedge clk) disable iff (rst)
    swp_busy |-> !ctl.ld1)
    else $error("item accepted during window recompute pass");

  a_wr_pos_step: assert property (@(posedge clk) disable iff (rst)
    ctl.ld1 && !ns_in |=> wr_pos == HIST_AW'($past(wr_pos) + HIST_AW'(1)))
    else $error("write position did not advance by one");

endmodule

[hw/rtl/mac_eval.sv]
// Crossover evaluation: cross products, compare, trade bookkeeping and result register.
// Depends on mac_pkg; fed by mac_window.
module mac_eval import mac_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  pipe_ctl_t               ctl,
  input  win_out_t                win,
  input  logic [LEN_W-1:0]        s_len,
  input  logic [LEN_W-1:0]        l_len,
  output logic signed [1:0]       signal,
  output logic                    evaluated,
  output logic                    signal_changed,
  output logic signed [PNL_W-1:0] running_pnl
);

  logic [PROD_W-1:0]     prod_a, prod_b;
  logic [PRICE_BITS-1:0] price3, price4;
  logic                  eval3, ns3, eval4, ns4;
  logic [1:0]            gen4;

  logic [1:0]            cur_sig, sig_base;
  logic [PRICE_BITS-1:0] last_px, last_base;
  logic                  has_trade, has_base;
  logic [PNL_W-1:0]      pnl, pnl_base, pnl_new;

  logic                  chg, ovf;
  logic [DELTA_W-1:0]    delta;
  logic [PNL_SUM_W-1:0]  psum;
  logic [PNL_SUM_W-PNL_W:0] hi;

  // short_sum * l_len against long_sum * s_len
  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      prod_a <= PROD_W'(win.short_sum) * PROD_W'(l_len);
      prod_b <= PROD_W'(win.long_sum) * PROD_W'(s_len);
      price3 <= win.price;
      eval3  <= win.eval;
      ns3    <= win.ns;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld4) begin
      if (prod_a > prod_b) begin
        gen4 <= SIG_POS;
      end else if (prod_a < prod_b) begin
        gen4 <= SIG_NEG;
      end else begin
        gen4 <= SIG_ZERO;
      end
      price4 <= price3;
      eval4  <= eval3;
      ns4    <= ns3;
    end
  end

  always_comb begin
    sig_base  = ns4 ? SIG_ZERO : cur_sig;
    last_base = ns4 ? '0 : last_px;
    has_base  = ns4 ? 1'b0 : has_trade;
    pnl_base  = ns4 ? '0 : pnl;
    chg       = eval4 && (gen4 != sig_base);
    // long to short closes at price - last; every other change the other way
    if (gen4 == SIG_NEG && sig_base == SIG_POS) begin
      delta = {1'b0, price4} - {1'b0, last_base};
    end else begin
      delta = {1'b0, last_base} - {1'b0, price4};
    end
    psum = {{(PNL_SUM_W - PNL_W){pnl_base[PNL_W-1]}}, pnl_base}
         + {{(PNL_SUM_W - DELTA_W){delta[DELTA_W-1]}}, delta};
    hi   = psum[PNL_SUM_W-1:PNL_W-1];
    ovf  = !((&hi) || !(|hi));
    if (!(chg && has_base)) begin
      pnl_new = pnl_base;
    end else if (ovf) begin
      pnl_new = psum[PNL_SUM_W-1] ? {1'b1, {(PNL_W - 1){1'b0}}} : {1'b0, {(PNL_W - 1){1'b1}}};
    end else begin
      pnl_new = psum[PNL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_sig   <= SIG_ZERO;
      last_px   <= '0;
      has_trade <= 1'b0;
      pnl       <= '0;
    end else if (ctl.ld_out) begin
      cur_sig   <= chg ? gen4 : sig_base;
      last_px   <= chg ? price4 : last_base;
      has_trade <= has_base | chg;
      pnl       <= pnl_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      signal         <= chg ? gen4 : sig_base;
      evaluated      <= eval4;
      signal_changed <= chg;
      running_pnl    <= pnl_new;
    end
  end

  a_trade_sticky: assert property (@(posedge clk) disable iff (rst)
    has_trade && !(ctl.ld_out && ns4) |=> has_trade)
    else $error("trade record lost without a new series");

  a_pnl_hold: assert property (@(posedge clk) disable iff (rst)
    ctl.ld_out && !chg && !ns4 |=> pnl == $past(pnl))
    else $error("PnL moved without a trade");

endmodule

[hw/rtl/moving_average_crossover_pnl.sv]
// Moving-average crossover with trade PnL: one result item per price item.
// Path: RAM read stage, window sum stage, product stage, compare stage, then the output register.
// Throughput: one item per cycle while out_ready holds and no recompute pass runs; the loop-carried
// window sums and trade state each close in a single stage around the two delay-line RAM reads.
// Reset (rst, synchronous): registers to 50/150/5, history valid bits, sums and trade state cleared.
// A write to either window length starts a recompute pass over the history; in_ready is low meanwhile.
module moving_average_crossover_pnl import mac_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [PRICE_W-1:0]      price,
  input  logic                    new_series,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [1:0]       signal,
  output logic                    evaluated,
  output logic                    signal_changed,
  output logic signed [PNL_W-1:0] running_pnl,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  logic [CFG_LEN_W-1:0] short_cfg, long_cfg;
  logic [STEP_W-1:0]    step_cfg;
  logic [LEN_W-1:0]     s_len, l_len;
  logic [STEP_W-1:0]    step;
  logic                 cfg_wr, resum, busy;

  logic      v1, v2, v3, v4;
  logic      e1, e2, e3, e4, e_out;
  pipe_ctl_t ctl;
  win_out_t  win;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign resum     = cfg_wr & (cfg_index == REG_SHORT_LEN || cfg_index == REG_LONG_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      short_cfg <= SHORT_LEN_RST;
      long_cfg  <= LONG_LEN_RST;
      step_cfg  <= EVAL_STEP_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_SHORT_LEN: short_cfg <= cfg_data;
        REG_LONG_LEN:  long_cfg  <= cfg_data;
        REG_EVAL_STEP: step_cfg  <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_len = clamp_len(short_cfg);
  assign l_len = clamp_len(long_cfg);
  assign step  = clamp_step(step_cfg);

  // A stage takes a new item when it is empty or its item moves on
  always_comb begin
    e_out      = ~out_valid | out_ready;
    e4         = ~v4 | e_out;
    e3         = ~v3 | e4;
    e2         = ~v2 | e3;
    e1         = ~v1 | e2;
    in_ready   = e1 & ~busy;
    ctl.ld1    = in_valid & in_ready;
    ctl.ld2    = v1 & e2;
    ctl.ld3    = v2 & e3;
    ctl.ld4    = v3 & e4;
    ctl.ld_out = v4 & e_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= ctl.ld1 | (v1 & ~e2);
      v2        <= ctl.ld2 | (v2 & ~e3);
      v3        <= ctl.ld3 | (v3 & ~e4);
      v4        <= ctl.ld4 | (v4 & ~e_out);
      out_valid <= ctl.ld_out | (out_valid & ~out_ready);
    end
  end

  mac_window u_window (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .price_in (PRICE_BITS'(price)),
    .ns_in    (new_series),
    .s_len    (s_len),
    .l_len    (l_len),
    .step     (step),
    .resum    (resum),
    .busy     (busy),
    .win      (win)
  );

  mac_eval u_eval (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .win            (win),
    .s_len          (s_len),
    .l_len          (l_len),
    .signal         (signal),
    .evaluated      (evaluated),
    .signal_changed (signal_changed),
    .running_pnl    (running_pnl)
  );

  a_len_write_pass: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == REG_LONG_LEN |=> busy && !in_ready)
    else $error("window length write did not start recompute");

  a_signal_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> signal == SIG_POS || signal == SIG_NEG || signal == SIG_ZERO)
    else $error("bad signal code on result");

  a_changed_eval: assert property (@(posedge clk) disable iff (rst)
    out_valid && signal_changed |-> evaluated)
    else $error("signal change reported without evaluation");

endmodule

[tb/sv/tb_moving_average_crossover_pnl.sv]
// Self-checking testbench for moving_average_crossover_pnl: crossover signal and trade PnL.
// Predicts every result item in-line and checks it field by field; depends on mac_pkg and the DUT.
`timescale 1ns / 100ps

module tb_moving_average_crossover_pnl;
  import mac_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
  localparam int  STALL_LIMIT = 2000;
  localparam int  DRAIN_CYCLES = 8;
  localparam longint PNL_HI = 64'sd140737488355327;
  localparam longint PNL_LO = -PNL_HI - 1;

  typedef struct packed {
    logic [1:0]       sig;
    logic             evald;
    logic             chg;
    logic [PNL_W-1:0] pnl;
  } xover_res_t;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic [PRICE_W-1:0]      price;
  logic                    new_series;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [1:0]       signal;
  logic                    evaluated;
  logic                    signal_changed;
  logic signed [PNL_W-1:0] running_pnl;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  moving_average_crossover_pnl u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .price          (price),
    .new_series     (new_series),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .signal         (signal),
    .evaluated      (evaluated),
    .signal_changed (signal_changed),
    .running_pnl    (running_pnl),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Predictor state
  logic [CFG_LEN_W-1:0] cfg_short;
  logic [CFG_LEN_W-1:0] cfg_long;
  logic [STEP_W-1:0]    cfg_step;
  logic [PRICE_W-1:0]   hist [MAX_WINDOW];
  logic [HIST_AW-1:0]   wr_ptr;
  int unsigned          n_samples;
  int unsigned          phase;
  logic [1:0]           cur_sig;
  logic [PRICE_W-1:0]   last_px;
  bit                   have_trade;
  longint               pnl_acc;

  xover_res_t pending_xover[$];
  xover_res_t got_exp;

  int  n_errors;
  int  n_results;
  int  idle_cycles;
  int  burst_left;
  bit  gaps_on;
  bit  stall_on;
  int  hold_req;
  int  hold_cnt;
  int  rx_phase;
  logic [PRICE_W-1:0] walk_px;
  bit  trend_up;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch %s: got %0h, want %0h (result %0d)", what, got, want, n_results);
    n_errors++;
  endtask

  function automatic int unsigned eff_len(input logic [CFG_LEN_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_WINDOW) return MAX_WINDOW;
    return int'(v);
  endfunction

  function automatic void clear_series();
    for (int i = 0; i < MAX_WINDOW; i++) hist[i] = '0;
    wr_ptr     = '0;
    n_samples  = 0;
    phase      = 0;
    cur_sig    = SIG_ZERO;
    last_px    = '0;
    have_trade = 1'b0;
    pnl_acc    = 0;
  endfunction

  // Expected result for one accepted price item
  function automatic void predict_crossover(input logic [PRICE_W-1:0] px, input logic ns);
    int unsigned s_len;
    int unsigned l_len;
    int unsigned stp;
    int unsigned span;
    logic [HIST_AW-1:0] idx;
    logic [63:0] ssum;
    logic [63:0] lsum;
    logic [63:0] lhs;
    logic [63:0] rhs;
    logic [1:0]  gen;
    longint      d;
    xover_res_t  r;
    s_len = eff_len(cfg_short);
    l_len = eff_len(cfg_long);
    stp   = (cfg_step == '0) ? 1 : int'(cfg_step);
    if (ns) clear_series();
    hist[wr_ptr] = px;
    if (n_samples < 65535) n_samples++;
    ssum = '0;
    lsum = '0;
    span = (s_len > l_len) ? s_len : l_len;
    for (int unsigned k = 0; k < span; k++) begin
      idx = wr_ptr - HIST_AW'(k);
      if (k < s_len) ssum += 64'(hist[idx]);
      if (k < l_len) lsum += 64'(hist[idx]);
    end
    wr_ptr++;
    r.evald = 1'b0;
    r.chg   = 1'b0;
    if (n_samples >= l_len) begin
      if (phase == 0) begin
        r.evald = 1'b1;
        lhs = ssum * 64'(l_len);
        rhs = lsum * 64'(s_len);
        gen = (lhs > rhs) ? SIG_POS : (lhs < rhs) ? SIG_NEG : SIG_ZERO;
        if (gen != cur_sig) begin
          r.chg = 1'b1;
          if (have_trade) begin
            // long exit on a fall to -1 earns price - entry; every other flip the reverse
            if (gen == SIG_NEG && cur_sig == SIG_POS)
              d = longint'({32'h0, px}) - longint'({32'h0, last_px});
            else
              d = longint'({32'h0, last_px}) - longint'({32'h0, px});
            d = d + pnl_acc;
            if (d > PNL_HI) d = PNL_HI;
            if (d < PNL_LO) d = PNL_LO;
            pnl_acc = d;
          end
          last_px    = px;
          have_trade = 1'b1;
          cur_sig    = gen;
        end
      end
      phase = (phase + 1 >= stp) ? 0 : phase + 1;
    end
    r.sig = cur_sig;
    r.pnl = pnl_acc[PNL_W-1:0];
    pending_xover.insert(pending_xover.size(), r);
  endfunction

  task automatic send_tick(input logic [PRICE_W-1:0] px, input logic ns);
    int gap;
    gap = 0;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 16);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    price      <= px;
    new_series <= ns;
    do begin
      @(posedge clk);
    end while (!in_ready);
    predict_crossover(px, ns);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_xover.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SHORT_LEN: cfg_short = val;
      REG_LONG_LEN:  cfg_long  = val;
      REG_EVAL_STEP: cfg_step  = val[STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input int s, input int l, input int st);
    write_reg(REG_SHORT_LEN, CFG_DATA_W'(s));
    write_reg(REG_LONG_LEN, CFG_DATA_W'(l));
    write_reg(REG_EVAL_STEP, CFG_DATA_W'(st));
  endtask

  // Trending random walk so the averages actually cross; now and then a wild jump
  function automatic logic [PRICE_W-1:0] next_price();
    int unsigned r;
    logic [PRICE_W-1:0] mv;
    r  = $urandom_range(0, 19);
    mv = PRICE_W'($urandom_range(0, 1 << 20));
    if ($urandom_range(0, 29) == 0) trend_up = ~trend_up;
    if (r == 0) walk_px = $urandom;
    else if ((r < 12) == trend_up) walk_px = walk_px + mv;
    else walk_px = walk_px - mv;
    return walk_px;
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 16);
    if (r < 9) return $urandom_range(17, 64);
    return $urandom_range(0, 511);
  endfunction

  function automatic int pick_step();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(1, 4);
    if (r < 9) return $urandom_range(5, 20);
    return $urandom_range(0, 255);
  endfunction

  task automatic test_reset_values();
    send_tick(next_price(), 1'b1);
    for (int i = 0; i < 170; i++) send_tick(next_price(), 1'b0);
  endtask

  task automatic test_price_extremes();
    set_regs(1, 2, 1);
    send_tick(32'h0000_0000, 1'b1);
    send_tick(32'hFFFF_FFFF, 1'b0);
    send_tick(32'h0000_0000, 1'b0);
    send_tick(32'h0000_0000, 1'b0);
    send_tick(32'hAAAA_AAAA, 1'b0);
    send_tick(32'h5555_5555, 1'b0);
    send_tick(32'h5555_5555, 1'b0);
    send_tick(32'hFFFF_FFFF, 1'b0);
    send_tick(32'hFFFF_FFFF, 1'b0);
    send_tick(32'h0000_0001, 1'b0);
    send_tick(32'h8000_0000, 1'b0);
    send_tick(32'h7FFF_FFFF, 1'b0);
    send_tick(32'h1234_5678, 1'b1);
    send_tick(32'h0001_0000, 1'b0);
    send_tick(32'hFFFF_0000, 1'b0);
    send_tick(32'h0000_FFFF, 1'b0);
    send_tick(32'hFFFF_FFFF, 1'b1);
    send_tick(32'h0000_0000, 1'b0);
    send_tick(32'hFFFF_FFFF, 1'b0);
    send_tick(32'h0000_0000, 1'b0);
  endtask

  task automatic test_reg_limits();
    // zero lengths act as one, so both averages match
    set_regs(0, 0, 0);
    send_tick(next_price(), 1'b1);
    for (int i = 0; i < 5; i++) send_tick(next_price(), 1'b0);
    // oversize lengths pin at the delay-line depth
    set_regs(300, 511, 0);
    send_tick(next_price(), 1'b1);
    for (int i = 0; i < 269; i++) send_tick(next_price(), 1'b0);
    // length change mid-series, sums rebuilt from history
    write_reg(REG_SHORT_LEN, CFG_DATA_W'(3));
    for (int i = 0; i < 20; i++) send_tick(next_price(), 1'b0);
    write_reg(REG_EVAL_STEP, CFG_DATA_W'(255));
    for (int i = 0; i < 20; i++) send_tick(next_price(), 1'b0);
    // leave the phase past a smaller step
    set_regs(2, 4, 20);
    send_tick(next_price(), 1'b1);
    for (int i = 0; i < 12; i++) send_tick(next_price(), 1'b0);
    write_reg(REG_EVAL_STEP, CFG_DATA_W'(3));
    for (int i = 0; i < 10; i++) send_tick(next_price(), 1'b0);
    // index past the register list must be ignored
    write_reg(REG_UNUSED, CFG_DATA_W'(511));
    for (int i = 0; i < 10; i++) send_tick(next_price(), 1'b0);
  endtask

  task automatic test_random_phases();
    int total;
    int n;
    total = 0;
    while (total < 1050) begin
      set_regs(pick_len(), pick_len(), pick_step());
      n = $urandom_range(50, 250);
      for (int i = 0; i < n; i++)
        send_tick(next_price(), (i == 0) ? 1'($urandom_range(0, 1))
                                         : 1'($urandom_range(0, 149) == 0));
      total += n;
    end
  endtask

  task automatic test_backpressure();
    set_regs(4, 12, 2);
    hold_req = 400;
    send_tick(next_price(), 1'b1);
    for (int i = 0; i < 80; i++) send_tick(next_price(), 1'b0);
  endtask

  // Alternating rails flip the signal every sample; each trade loses the full price range
  task automatic test_long_series();
    set_regs(1, 2, 1);
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    send_tick(32'h0000_0000, 1'b1);
    for (int i = 1; i < 150; i++)
      send_tick(i[0] ? 32'hFFFF_FFFF : 32'h0000_0000, 1'b0);
    wait_drained();
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_xover.size() == 0) begin
        flag_mismatch("result with nothing pending", 64'(running_pnl), 64'h0);
      end else begin
        got_exp = pending_xover.pop_front();
        if (signal !== got_exp.sig)
          flag_mismatch("signal", 64'(signal), 64'(got_exp.sig));
        if (evaluated !== got_exp.evald)
          flag_mismatch("evaluated", 64'(evaluated), 64'(got_exp.evald));
        if (signal_changed !== got_exp.chg)
          flag_mismatch("signal_changed", 64'(signal_changed), 64'(got_exp.chg));
        if (running_pnl !== got_exp.pnl)
          flag_mismatch("running_pnl", 64'(running_pnl), 64'(got_exp.pnl));
      end
      n_results++;
    end
  end

  // Receiver: rotating stall pattern, plus a long hold on request
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    rx_phase++;
    if (hold_cnt > 0) begin
      out_ready <= 1'b0;
      hold_cnt--;
    end else if (!stall_on) begin
      out_ready <= 1'b1;
    end else begin
      case (rx_phase[7:6])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= ($urandom_range(0, 3) != 0);
        2'd2: out_ready <= ($urandom_range(0, 2) == 0);
        default: out_ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // Watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("** moving_average_crossover_pnl: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    price      <= '0;
    new_series <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    out_ready  <= 1'b0;
    n_errors    = 0;
    n_results   = 0;
    idle_cycles = 0;
    burst_left  = 0;
    gaps_on     = 1'b1;
    stall_on    = 1'b1;
    hold_req    = 0;
    hold_cnt    = 0;
    rx_phase    = 0;
    walk_px     = 32'h0064_0000;
    trend_up    = 1'b1;
    cfg_short   = SHORT_LEN_RST;
    cfg_long    = LONG_LEN_RST;
    cfg_step    = EVAL_STEP_RST;
    clear_series();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_price_extremes();
    test_reg_limits();
    test_random_phases();
    test_backpressure();
    test_long_series();

    wait_drained();
    if (pending_xover.size() != 0)
      flag_mismatch("results never arrived", 64'(pending_xover.size()), 64'h0);
    if (n_errors == 0) begin
      $display("** moving_average_crossover_pnl: PASSED **");
    end else begin
      $display("** moving_average_crossover_pnl: FAILED **");
    end
    $finish;
  end

endmodule
